// File: hdl/tmn_pkg.sv
// ----------------------------------------------------------------------------
// Thruster mixer package
// Shared widths, command codes, the microcode word format and the control
// program that sequences the mixer datapath.
// ----------------------------------------------------------------------------
package tmn_pkg;

    // Fixed-point format of every level and power (signed Q2.14).
    localparam int FRACTION_BITS = 14;
    localparam int LEVEL_W       = 16;
    localparam int LIMIT_W       = LEVEL_W - 1;
    localparam int MAG_W         = FRACTION_BITS + 1;
    localparam int SUM_W         = MAG_W + 2;
    localparam int REM_W         = SUM_W + 1;
    localparam int CNT_W         = $clog2(FRACTION_BITS + 1);
    localparam int ONE           = 1 << FRACTION_BITS;

    // Yaw limit after reset is 0.4 rounded to the nearest code.
    localparam logic [LIMIT_W-1:0] YAW_LIMIT_RESET = LIMIT_W'((ONE * 2 + 2) / 5);

    // Command codes.
    typedef enum logic [2:0] {
        CMD_THROTTLE = 3'd0,
        CMD_YAW      = 3'd1,
        CMD_PITCH    = 3'd2,
        CMD_ROLL     = 3'd3,
        CMD_DISARM   = 3'd4
    } t_cmd;

    // Datapath operation of one microcode step.
    typedef enum logic [3:0] {
        OP_NOP,
        OP_UPDATE,
        OP_LIMIT,
        OP_LOAD_P,
        OP_LOAD_Y,
        OP_ITER,
        OP_STORE_P,
        OP_STORE_Y,
        OP_MIX
    } t_op;

    // Sequencing condition of one microcode step.
    typedef enum logic [2:0] {
        COND_NEXT,
        COND_WAIT_IN,
        COND_DISARM,
        COND_SUM_OK,
        COND_DIV_MORE,
        COND_WAIT_OUT
    } t_cond;

    localparam int PC_W = 4;

    typedef struct packed {
        t_op             op;
        t_cond           cond;
        logic [PC_W-1:0] target;
    } t_uword;

    // Control of the shared divider.
    typedef struct packed {
        logic load;
        logic step;
    } t_div_ctl;

    // Program addresses that are jump targets.
    localparam logic [PC_W-1:0] STEP_WAIT   = PC_W'(0);
    localparam logic [PC_W-1:0] STEP_ITER_P = PC_W'(4);
    localparam logic [PC_W-1:0] STEP_ITER_Y = PC_W'(7);
    localparam logic [PC_W-1:0] STEP_MIX    = PC_W'(9);

    // Control program: one word per step.
    function automatic t_uword uprog(input logic [PC_W-1:0] pc);
        t_uword w;
        w = '{op: OP_NOP, cond: COND_NEXT, target: STEP_WAIT};
        case (pc)
            PC_W'(0): w = '{op: OP_NOP,     cond: COND_WAIT_IN,  target: STEP_WAIT};
            PC_W'(1): w = '{op: OP_UPDATE,  cond: COND_DISARM,   target: STEP_MIX};
            PC_W'(2): w = '{op: OP_LIMIT,   cond: COND_NEXT,     target: STEP_WAIT};
            PC_W'(3): w = '{op: OP_LOAD_P,  cond: COND_SUM_OK,   target: STEP_MIX};
            PC_W'(4): w = '{op: OP_ITER,    cond: COND_DIV_MORE, target: STEP_ITER_P};
            PC_W'(5): w = '{op: OP_STORE_P, cond: COND_NEXT,     target: STEP_WAIT};
            PC_W'(6): w = '{op: OP_LOAD_Y,  cond: COND_NEXT,     target: STEP_WAIT};
            PC_W'(7): w = '{op: OP_ITER,    cond: COND_DIV_MORE, target: STEP_ITER_Y};
            PC_W'(8): w = '{op: OP_STORE_Y, cond: COND_NEXT,     target: STEP_WAIT};
            PC_W'(9): w = '{op: OP_MIX,     cond: COND_WAIT_OUT, target: STEP_WAIT};
            default:  w = '{op: OP_NOP,     cond: COND_NEXT,     target: STEP_WAIT};
        endcase
        return w;
    endfunction

endpackage

// File: hdl/thruster_mixer_normalizer_core.sv
// ----------------------------------------------------------------------------
// Thruster mixer with normalization
// Four-engine mixer: commands set throttle, yaw, pitch or roll, or disarm.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid / o_in_stall) carries one command and a signed
//   Q2.14 value per transfer. Output channel (o_out_valid / i_out_stall)
//   carries the four engine powers and the disarmed flag, one result per
//   command. The user must write the yaw limit register through i_cfg_we/i_cfg_data
//   only while the block is idle; the block itself does not enforce this.
//   A small microcode program sequences one shared datapath and a one bit
//   per cycle divider. A command goes through update, yaw limit and the
//   sum check to the mix step; a disarm goes from update straight to mix.
//   When pitch, roll and limited yaw magnitudes sum above one, the divider
//   scales pitch and then yaw before the mix. A new command is taken only
//   after the result of the last one is registered.
//   The result sits in an output register; while the receiver stalls, the
//   next command is processed and waits only at its final mix step.
//   Reset clears all levels, sets the yaw limit to 0.4 and empties the
//   output register.
// ----------------------------------------------------------------------------
module thruster_mixer_normalizer_core (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [tmn_pkg::LIMIT_W-1:0]         i_cfg_data,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic [2:0]                          i_cmd,
    input  logic signed [tmn_pkg::LEVEL_W-1:0]  i_value,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic signed [tmn_pkg::LEVEL_W-1:0]  o_engine_zero_power,
    output logic signed [tmn_pkg::LEVEL_W-1:0]  o_engine_one_power,
    output logic signed [tmn_pkg::LEVEL_W-1:0]  o_engine_two_power,
    output logic signed [tmn_pkg::LEVEL_W-1:0]  o_engine_three_power,
    output logic                                o_disarmed
);
    import tmn_pkg::*;

    localparam logic signed [LEVEL_W-1:0] ONE_L     = LEVEL_W'(ONE);
    localparam logic signed [LEVEL_W-1:0] NEG_ONE_L = -ONE_L;

    // Magnitude of a level that stays within plus or minus one.
    function automatic logic [MAG_W-1:0] mag(input logic signed [LEVEL_W-1:0] v);
        logic signed [LEVEL_W-1:0] a;
        a = (v < 0) ? -v : v;
        return a[MAG_W-1:0];
    endfunction

    // Sequencer and control state.
    logic [PC_W-1:0]           r_pc;
    logic [PC_W-1:0]           n_pc;
    logic                      r_out_valid;
    logic [LIMIT_W-1:0]        r_yaw_limit;

    // Axis levels.
    logic signed [LEVEL_W-1:0] r_throttle;
    logic signed [LEVEL_W-1:0] r_yaw;
    logic signed [LEVEL_W-1:0] r_pitch;
    logic signed [LEVEL_W-1:0] r_roll;

    // Working registers of the current command.
    t_cmd                      r_cmd;
    logic signed [LEVEL_W-1:0] r_value;
    logic                      r_dis;
    logic signed [LEVEL_W-1:0] r_p;
    logic signed [LEVEL_W-1:0] r_y;
    logic [SUM_W-1:0]          r_sum;

    // Output register.
    logic signed [LEVEL_W-1:0] r_e0;
    logic signed [LEVEL_W-1:0] r_e1;
    logic signed [LEVEL_W-1:0] r_e2;
    logic signed [LEVEL_W-1:0] r_e3;
    logic                      r_o_dis;

    t_uword                    uw;
    t_div_ctl                  div_ctl;
    logic                      in_xfer;
    logic                      out_free;
    logic signed [LEVEL_W-1:0] req;
    logic [LIMIT_W-1:0]        lim;
    logic signed [LEVEL_W-1:0] lim_s;
    logic signed [LEVEL_W-1:0] y_lim;
    logic [SUM_W-1:0]          sum;
    logic [MAG_W-1:0]          div_num;
    logic [MAG_W-1:0]          div_quot;
    logic                      div_last;
    logic signed [LEVEL_W-1:0] quot_s;
    logic signed [LEVEL_W-1:0] p_norm;
    logic signed [LEVEL_W-1:0] y_norm;

    // Current control word and handshake qualifiers.
    always_comb begin
        uw       = uprog(r_pc);
        in_xfer  = i_in_valid && (uw.cond == COND_WAIT_IN);
        out_free = !r_out_valid || !i_out_stall;
        div_ctl.load = (uw.op == OP_LOAD_P) || (uw.op == OP_LOAD_Y);
        div_ctl.step = (uw.op == OP_ITER);
    end

    // Clamp the requested value, limit yaw and sum the magnitudes.
    always_comb begin
        if (r_value > ONE_L) begin
            req = ONE_L;
        end else if (r_value < NEG_ONE_L) begin
            req = NEG_ONE_L;
        end else begin
            req = r_value;
        end

        lim   = (r_yaw_limit > LIMIT_W'(ONE)) ? LIMIT_W'(ONE) : r_yaw_limit;
        lim_s = signed'({1'b0, lim});
        if (r_yaw > lim_s) begin
            y_lim = lim_s;
        end else if (r_yaw < -lim_s) begin
            y_lim = -lim_s;
        end else begin
            y_lim = r_yaw;
        end

        sum = SUM_W'(mag(r_pitch)) + SUM_W'(mag(r_roll)) + SUM_W'(mag(y_lim));
    end

    // Divider operand and signed quotient.
    always_comb begin
        div_num = (uw.op == OP_LOAD_Y) ? mag(r_y) : mag(r_p);
        quot_s  = signed'(LEVEL_W'(div_quot));
        p_norm  = r_p[LEVEL_W-1] ? -quot_s : quot_s;
        y_norm  = r_y[LEVEL_W-1] ? -quot_s : quot_s;
    end

    tmn_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (div_ctl),
        .i_num   (div_num),
        .i_den   (r_sum),
        .o_quot  (div_quot),
        .o_last  (div_last)
    );

    // Next program step.
    always_comb begin
        case (uw.cond)
            COND_NEXT:     n_pc = r_pc + PC_W'(1);
            COND_WAIT_IN:  n_pc = in_xfer ? r_pc + PC_W'(1) : r_pc;
            COND_DISARM:   n_pc = (r_cmd == CMD_DISARM) ? uw.target : r_pc + PC_W'(1);
            COND_SUM_OK:   n_pc = (r_sum <= SUM_W'(ONE)) ? uw.target : r_pc + PC_W'(1);
            COND_DIV_MORE: n_pc = div_last ? r_pc + PC_W'(1) : uw.target;
            COND_WAIT_OUT: n_pc = out_free ? uw.target : r_pc;
            default:       n_pc = STEP_WAIT;
        endcase
    end

    // Sequencer, levels, working registers and output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc        <= STEP_WAIT;
            r_out_valid <= 1'b0;
            r_yaw_limit <= YAW_LIMIT_RESET;
            r_throttle  <= '0;
            r_yaw       <= '0;
            r_pitch     <= '0;
            r_roll      <= '0;
        end else begin
            r_pc <= n_pc;

            if (i_cfg_we) begin
                r_yaw_limit <= i_cfg_data;
            end

            if (in_xfer) begin
                r_cmd   <= t_cmd'(i_cmd);
                r_value <= i_value;
            end

            // A mixed result fills the output register; otherwise the receiver
            // may take the held result.
            if ((uw.op == OP_MIX) && out_free) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end

            case (uw.op)
                OP_UPDATE: begin
                    r_dis <= (r_cmd == CMD_DISARM);
                    case (r_cmd)
                        CMD_THROTTLE: r_throttle <= req;
                        CMD_YAW:      r_yaw      <= req;
                        CMD_PITCH:    r_pitch    <= req;
                        CMD_ROLL:     r_roll     <= req;
                        CMD_DISARM: begin
                            r_throttle <= '0;
                            r_yaw      <= '0;
                            r_pitch    <= '0;
                            r_roll     <= '0;
                        end
                        default: ;
                    endcase
                end
                OP_LIMIT: begin
                    r_p   <= r_pitch;
                    r_y   <= y_lim;
                    r_sum <= sum;
                end
                OP_STORE_P: r_p <= p_norm;
                OP_STORE_Y: r_y <= y_norm;
                OP_MIX: begin
                    if (out_free) begin
                        r_o_dis <= r_dis;
                        if (r_dis) begin
                            r_e0 <= '0;
                            r_e1 <= '0;
                            r_e2 <= '0;
                            r_e3 <= '0;
                        end else begin
                            r_e0 <= r_throttle;
                            r_e1 <= r_p + r_y;
                            r_e2 <= r_p - r_y;
                            r_e3 <= r_throttle;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    assign o_in_stall           = (uw.cond != COND_WAIT_IN);
    assign o_out_valid          = r_out_valid;
    assign o_engine_zero_power  = r_e0;
    assign o_engine_one_power   = r_e1;
    assign o_engine_two_power   = r_e2;
    assign o_engine_three_power = r_e3;
    assign o_disarmed           = r_o_dis;

endmodule

// File: hdl/tmn_div.sv
// ----------------------------------------------------------------------------
// Thruster mixer divider
// Restoring divider that computes floor(num * ONE / den) one quotient bit per
// cycle, for numerators no larger than the denominator.
// ----------------------------------------------------------------------------
module tmn_div (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  tmn_pkg::t_div_ctl           i_ctl,
    input  logic [tmn_pkg::MAG_W-1:0]   i_num,
    input  logic [tmn_pkg::SUM_W-1:0]   i_den,
    output logic [tmn_pkg::MAG_W-1:0]   o_quot,
    output logic                        o_last
);
    import tmn_pkg::*;

    logic [REM_W-1:0] r_rem;
    logic [MAG_W-1:0] r_quot;
    logic [CNT_W-1:0] r_cnt;

    logic [REM_W-1:0] load_rem;
    logic [REM_W-1:0] step_rem;
    logic [REM_W-1:0] den_ext;
    logic             load_ge;
    logic             step_ge;

    // Trial subtraction for the first bit and for each following bit.
    always_comb begin
        den_ext  = REM_W'(i_den);
        load_rem = REM_W'(i_num);
        load_ge  = load_rem >= den_ext;
        step_rem = {r_rem[REM_W-2:0], 1'b0};
        step_ge  = step_rem >= den_ext;
    end

    // Remainder, quotient and bit counter.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_ctl.load) begin
            r_rem  <= load_ge ? load_rem - den_ext : load_rem;
            r_quot <= MAG_W'(load_ge);
            r_cnt  <= CNT_W'(FRACTION_BITS);
        end else if (i_ctl.step) begin
            r_rem  <= step_ge ? step_rem - den_ext : step_rem;
            r_quot <= {r_quot[MAG_W-2:0], step_ge};
            r_cnt  <= r_cnt - CNT_W'(1);
        end
    end

    assign o_quot = r_quot;
    assign o_last = (r_cnt == CNT_W'(1));

endmodule
